/* sv/solar_power_hourly_energy_defines.svh */
// assertion macros for the solar hourly energy block
`ifndef SOLAR_POWER_HOURLY_ENERGY_DEFINES_SVH
`define SOLAR_POWER_HOURLY_ENERGY_DEFINES_SVH

`ifndef SYNTHESIS
`define SPHE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sphe: assertion failed");
`define SPHE_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sphe: reset assertion failed");
`else
`define SPHE_ASSERT(lbl, prop)
`define SPHE_ASSERT_RST(lbl, prop)
`endif

`endif

/* sv/sphe_pkg.sv */
// shared types and constants of the solar hourly energy block
`default_nettype none

package sphe_pkg;

  localparam int WINDOW_DEPTH = 60;

  localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

  localparam int TEMP_W   = 16;
  localparam int MOD_W    = 7;
  localparam int FLOW_W   = 10;
  localparam int FLOW10_W = 14;
  localparam int POWER_W  = 26;
  localparam int ENERGY_W = 29;
  localparam int PROD1_W  = TEMP_W + MOD_W;
  localparam int PROD2_W  = PROD1_W + FLOW10_W;
  localparam int SUM_W    = POWER_W + FILL_W;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_DEPTH);

  localparam logic [MOD_W-1:0] BOOST_LEVEL = 7'd100;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_MODULATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FLOW       = 2'd1;

  // two-digit division by a constant: high digit, then remainder joined to low digit
  localparam int DIGIT_W  = 20;
  localparam int DSRC_W   = 40;
  localparam int DNUM_W   = 31;
  localparam int DREM_W   = 11;
  localparam int RECIP_W  = 32;
  localparam int DPROD_W  = DNUM_W + RECIP_W;

  localparam logic [DREM_W-1:0] FLOW_DIVISOR   = 11'd1665;
  localparam logic [DREM_W-1:0] ENERGY_DIVISOR = 11'd6;
  localparam int FLOW_SHIFT   = 41;
  localparam int ENERGY_SHIFT = 34;
  localparam logic [RECIP_W-1:0] FLOW_RECIP   = RECIP_W'((64'd1 << FLOW_SHIFT) / 1665);
  localparam logic [RECIP_W-1:0] ENERGY_RECIP = RECIP_W'((64'd1 << ENERGY_SHIFT) / 6);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV_HI,
    ST_FIX_HI,
    ST_DIV_LO,
    ST_FIX_LO,
    ST_PUSH,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

/* sv/solar_power_hourly_energy.sv */
// top level of the solar collector hourly energy estimator
`default_nettype none

`include "solar_power_hourly_energy_defines.svh"

// Takes one monitor sample per transfer and returns one result per sample.
// A sample without the broadcast flag only masks the pump boost and repeats
// the held power and energy, and its result register is loaded as soon as
// the output is free; a stalled output holds the load back.
// A broadcast sample runs two multiplier steps for the power product, a
// two-digit reciprocal divider run once for /1665 and again for the hour
// sum /6, and one write of the 60-entry power window memory in between,
// before its result register is loaded. The next sample is taken the cycle
// after the result register is loaded, even while that result still waits
// on the output. The window memory needs no clearing after reset; only
// written entries are ever used.
module solar_power_hourly_energy (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // collector_temp[15:0], tank_temp[31:16], pump_modulation[38:32], zero pad
  input  wire logic [sphe_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // is_broadcast
  input  wire logic                               s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // modulation_out[6:0], solar_power[32:7], energy_last_hour[61:33], zero pad
  output logic      [sphe_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [sphe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sphe_pkg::CFG_DATA_W-1:0]    cfg_data
);

  sphe_pkg::state_t state, state_next;

  logic [sphe_pkg::MOD_W-1:0]    min_modulation;
  logic [sphe_pkg::FLOW10_W-1:0] flow_x10;
  logic [sphe_pkg::MOD_W-1:0]    previous_modulation;
  logic [sphe_pkg::PTR_W-1:0]    window_pointer;
  logic [sphe_pkg::FILL_W-1:0]   window_fill;
  logic [sphe_pkg::SUM_W-1:0]    window_sum;
  logic [sphe_pkg::POWER_W-1:0]  held_power;
  logic [sphe_pkg::ENERGY_W-1:0] held_energy;
  logic                          div_energy;

  logic [sphe_pkg::TEMP_W-1:0]  diff_pos;
  logic [sphe_pkg::MOD_W-1:0]   mod_r;
  logic                         bcast_r;
  logic [sphe_pkg::PROD1_W-1:0] prod1;
  logic [sphe_pkg::PROD2_W-1:0] prod2;

  logic [sphe_pkg::DNUM_W-1:0] q_est;
  logic [sphe_pkg::DNUM_W-1:0] q_hi;
  logic [sphe_pkg::DREM_W-1:0] rem;

  logic in_xfer, out_load, ram_we;
  logic [sphe_pkg::POWER_W-1:0] ram_rdata;

  // ---------------------------------------------------------------- input side
  logic signed [sphe_pkg::TEMP_W-1:0] coll_temp, tank_temp;
  logic signed [sphe_pkg::TEMP_W:0]   diff_full;
  logic [sphe_pkg::MOD_W-1:0]         mod_in, mod_masked;

  assign coll_temp = s_axis_tdata[15:0];
  assign tank_temp = s_axis_tdata[31:16];
  assign mod_in    = s_axis_tdata[38:32];
  assign diff_full = {coll_temp[15], coll_temp} - {tank_temp[15], tank_temp};

  // a jump from zero straight to full is a boost, reported as the minimum
  assign mod_masked = (previous_modulation == '0 && mod_in == sphe_pkg::BOOST_LEVEL)
                      ? min_modulation : mod_in;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- divider
  logic [sphe_pkg::DSRC_W-1:0]  div_src;
  logic [sphe_pkg::DNUM_W-1:0]  dv_n;
  logic [sphe_pkg::DREM_W-1:0]  dv_divisor;
  logic [sphe_pkg::RECIP_W-1:0] dv_recip;
  logic [sphe_pkg::DPROD_W-1:0] dv_prod;
  logic [sphe_pkg::DNUM_W-1:0]  dv_q;
  logic [41:0]                  dv_qd;
  logic [sphe_pkg::DNUM_W-1:0]  dv_rem_full;
  logic [11:0]                  dv_rem12;
  logic                         dv_fix;
  logic [sphe_pkg::DNUM_W-1:0]  dv_q_fix;
  logic [sphe_pkg::DREM_W-1:0]  dv_r_fix;
  logic                         lo_phase;
  logic [sphe_pkg::DNUM_W-1:0]  quot_lo;

  assign div_src = div_energy
                   ? {{(sphe_pkg::DSRC_W - sphe_pkg::SUM_W){1'b0}}, window_sum}
                   : {{(sphe_pkg::DSRC_W - sphe_pkg::PROD2_W){1'b0}}, prod2};

  assign lo_phase = (state == sphe_pkg::ST_DIV_LO) || (state == sphe_pkg::ST_FIX_LO);

  assign dv_n = lo_phase
                ? {rem, div_src[sphe_pkg::DIGIT_W-1:0]}
                : {11'b0, div_src[sphe_pkg::DSRC_W-1:sphe_pkg::DIGIT_W]};

  assign dv_divisor = div_energy ? sphe_pkg::ENERGY_DIVISOR : sphe_pkg::FLOW_DIVISOR;
  assign dv_recip   = div_energy ? sphe_pkg::ENERGY_RECIP : sphe_pkg::FLOW_RECIP;
  assign dv_prod    = {{sphe_pkg::RECIP_W{1'b0}}, dv_n}
                    * {{sphe_pkg::DNUM_W{1'b0}}, dv_recip};

  // estimate is the true quotient or one below it
  assign dv_q = div_energy
                ? {2'b0, dv_prod[sphe_pkg::DPROD_W-1:sphe_pkg::ENERGY_SHIFT]}
                : {9'b0, dv_prod[sphe_pkg::DPROD_W-1:sphe_pkg::FLOW_SHIFT]};

  assign dv_qd       = {11'b0, q_est} * {31'b0, dv_divisor};
  assign dv_rem_full = dv_n - dv_qd[sphe_pkg::DNUM_W-1:0];
  assign dv_rem12    = dv_rem_full[11:0];
  assign dv_fix      = dv_rem12 >= {1'b0, dv_divisor};
  assign dv_q_fix    = q_est + {30'b0, dv_fix};
  assign dv_r_fix    = sphe_pkg::DREM_W'(dv_rem12 - (dv_fix ? {1'b0, dv_divisor} : 12'd0));
  assign quot_lo     = dv_q_fix;

  // ---------------------------------------------------------------- window update
  logic                         window_full;
  logic [sphe_pkg::SUM_W-1:0]   sum_next;
  logic [sphe_pkg::PTR_W-1:0]   pointer_next;

  assign window_full  = window_fill >= sphe_pkg::FILL_MAX;
  assign sum_next     = window_sum
                      - (window_full ? {{sphe_pkg::FILL_W{1'b0}}, ram_rdata} : '0)
                      + {{sphe_pkg::FILL_W{1'b0}}, held_power};
  assign pointer_next = (window_pointer == sphe_pkg::PTR_LAST) ? '0 : window_pointer + 1'b1;

  // the read address is the write pointer, which holds from transfer to push,
  // so the old entry is on ram_rdata by the push cycle
  sphe_ram #(
    .WIDTH (sphe_pkg::POWER_W),
    .DEPTH (sphe_pkg::WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (window_pointer),
    .wdata (held_power),
    .raddr (window_pointer),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sphe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sphe_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_next = s_axis_tuser ? sphe_pkg::ST_MUL1 : sphe_pkg::ST_OUT;
        end
      end
      sphe_pkg::ST_MUL1:   state_next = sphe_pkg::ST_MUL2;
      sphe_pkg::ST_MUL2:   state_next = sphe_pkg::ST_DIV_HI;
      sphe_pkg::ST_DIV_HI: state_next = sphe_pkg::ST_FIX_HI;
      sphe_pkg::ST_FIX_HI: state_next = sphe_pkg::ST_DIV_LO;
      sphe_pkg::ST_DIV_LO: state_next = sphe_pkg::ST_FIX_LO;
      sphe_pkg::ST_FIX_LO: state_next = div_energy ? sphe_pkg::ST_OUT : sphe_pkg::ST_PUSH;
      sphe_pkg::ST_PUSH:   state_next = sphe_pkg::ST_DIV_HI;
      sphe_pkg::ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = sphe_pkg::ST_IDLE;
        end
      end
      default: state_next = sphe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      sphe_pkg::ST_IDLE: s_axis_tready = 1'b1;
      sphe_pkg::ST_PUSH: ram_we = 1'b1;
      sphe_pkg::ST_OUT:  out_load = !m_axis_tvalid || m_axis_tready;
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_modulation      <= '0;
      flow_x10            <= '0;
      previous_modulation <= '0;
      window_pointer      <= '0;
      window_fill         <= '0;
      window_sum          <= '0;
      held_power          <= '0;
      held_energy         <= '0;
      div_energy          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sphe_pkg::REG_MIN_MODULATION: min_modulation <= cfg_data[sphe_pkg::MOD_W-1:0];
          sphe_pkg::REG_MAX_FLOW: flow_x10 <= ({4'b0, cfg_data} << 3) + ({4'b0, cfg_data} << 1);
          default: begin
          end
        endcase
      end
      if (in_xfer) begin
        previous_modulation <= mod_masked;
        div_energy          <= 1'b0;
      end
      if (state == sphe_pkg::ST_FIX_LO) begin
        if (div_energy) begin
          // saturate anything past the field width
          held_energy <= (q_hi[sphe_pkg::DNUM_W-1:9] != '0) ? '1
                         : {q_hi[8:0], quot_lo[sphe_pkg::DIGIT_W-1:0]};
        end else begin
          held_power <= {q_hi[5:0], quot_lo[sphe_pkg::DIGIT_W-1:0]};
        end
      end
      if (state == sphe_pkg::ST_PUSH) begin
        window_sum     <= sum_next;
        window_pointer <= pointer_next;
        div_energy     <= 1'b1;
        if (!window_full) begin
          window_fill <= window_fill + 1'b1;
        end
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mod_r    <= mod_masked;
      bcast_r  <= s_axis_tuser;
      diff_pos <= (!diff_full[sphe_pkg::TEMP_W] && diff_full != '0)
                  ? diff_full[sphe_pkg::TEMP_W-1:0] : '0;
    end
    case (state) inside
      sphe_pkg::ST_MUL1: prod1 <= {7'b0, diff_pos} * {16'b0, mod_r};
      sphe_pkg::ST_MUL2: prod2 <= {14'b0, prod1} * {23'b0, flow_x10};
      sphe_pkg::ST_DIV_HI, sphe_pkg::ST_DIV_LO: q_est <= dv_q;
      sphe_pkg::ST_FIX_HI: begin
        q_hi <= dv_q_fix;
        rem  <= dv_r_fix;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {2'b0, held_energy, held_power, mod_r};
    end
  end

  // ---------------------------------------------------------------- checks
  `SPHE_ASSERT(a_accept_leaves_idle, (s_axis_tvalid && s_axis_tready) |=> (state != sphe_pkg::ST_IDLE))
  `SPHE_ASSERT(a_high_remainder_below_divisor, (state == sphe_pkg::ST_FIX_HI) |=> (rem < dv_divisor))
  `SPHE_ASSERT(a_fill_bounded, (window_fill <= sphe_pkg::FILL_MAX) && (bcast_r || state != sphe_pkg::ST_MUL1))
  `SPHE_ASSERT_RST(a_reset_idle, rst |=> (state == sphe_pkg::ST_IDLE) && !m_axis_tvalid)

endmodule

`default_nettype wire

/* sv/sphe_ram.sv */
// generic single-write, single-read memory with registered read data
`default_nettype none

module sphe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// self-checking testbench for the solar collector hourly energy estimator
`default_nettype none

module tb_top;

  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MISMATCH_PRINTS = 10;
  localparam int EXPECT_DEPTH = 64;
  localparam longint unsigned FLOW_DIV = 1665;
  localparam longint unsigned FLOW_SCALE = 10;
  localparam longint unsigned HOUR_DIV = 6;
  localparam longint unsigned ENERGY_CEIL = (64'd1 << sphe_pkg::ENERGY_W) - 1;
  // indexes past the register list, writes there must change nothing
  localparam logic [sphe_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [sphe_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic signed [sphe_pkg::TEMP_W-1:0] collector;
    logic signed [sphe_pkg::TEMP_W-1:0] tank;
    logic [sphe_pkg::MOD_W-1:0]         modulation;
    logic                               broadcast;
  } sample_t;

  typedef struct packed {
    logic [sphe_pkg::MOD_W-1:0]    modulation;
    logic [sphe_pkg::POWER_W-1:0]  power;
    logic [sphe_pkg::ENERGY_W-1:0] energy;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [sphe_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [sphe_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sphe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sphe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [sphe_pkg::MOD_W-1:0]    min_mod_setting = '0;
  logic [sphe_pkg::FLOW_W-1:0]   max_flow_setting = '0;
  logic [sphe_pkg::POWER_W-1:0]  power_hist [sphe_pkg::WINDOW_DEPTH];
  int                            hist_slot = 0;
  int                            hist_count = 0;
  longint unsigned               hist_sum = 0;
  logic [sphe_pkg::MOD_W-1:0]    last_modulation = '0;
  logic [sphe_pkg::POWER_W-1:0]  held_power = '0;
  logic [sphe_pkg::ENERGY_W-1:0] held_energy = '0;

  // expected results in transfer order
  reading_t expected_fifo [EXPECT_DEPTH];
  int expect_wr = 0;
  int expect_rd = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  solar_power_hourly_energy uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // masks the boost, then on a broadcast estimates power and rolls the hour window
  function automatic reading_t estimate_sample(sample_t s);
    reading_t r;
    logic [sphe_pkg::MOD_W-1:0] m;
    int delta;
    longint unsigned prod;
    longint unsigned e;
    m = s.modulation;
    if (last_modulation == '0 && m == sphe_pkg::BOOST_LEVEL) m = min_mod_setting;
    last_modulation = m;
    if (s.broadcast) begin
      delta = int'($signed(s.collector)) - int'($signed(s.tank));
      if (delta <= 0) begin
        held_power = '0;
      end else begin
        prod = longint'(delta) * longint'(m) * longint'(max_flow_setting) * FLOW_SCALE
               / FLOW_DIV;
        held_power = prod[sphe_pkg::POWER_W-1:0];
      end
      if (hist_count >= sphe_pkg::WINDOW_DEPTH) hist_sum -= power_hist[hist_slot];
      else hist_count++;
      power_hist[hist_slot] = held_power;
      hist_sum += held_power;
      hist_slot = (hist_slot == sphe_pkg::WINDOW_DEPTH - 1) ? 0 : hist_slot + 1;
      e = hist_sum / HOUR_DIV;
      held_energy = (e > ENERGY_CEIL) ? ENERGY_CEIL[sphe_pkg::ENERGY_W-1:0]
                                      : e[sphe_pkg::ENERGY_W-1:0];
    end
    r.modulation = m;
    r.power = held_power;
    r.energy = held_energy;
    return r;
  endfunction

  function automatic sample_t make_sample(int c, int t, int m, bit b);
    sample_t s;
    s.collector = c[sphe_pkg::TEMP_W-1:0];
    s.tank = t[sphe_pkg::TEMP_W-1:0];
    s.modulation = m[sphe_pkg::MOD_W-1:0];
    s.broadcast = b;
    return s;
  endfunction

  function automatic sample_t random_sample();
    int c;
    int t;
    int m;
    if ($urandom_range(99) < 70) begin
      // plausible collector field values, the difference swings both ways
      c = int'($urandom_range(1400)) - 200;
      t = int'($urandom_range(900)) - 100;
    end else begin
      c = int'($urandom_range(16'hFFFF));
      t = int'($urandom_range(16'hFFFF));
    end
    case ($urandom_range(9))
      0, 1, 2: m = 0;
      3, 4:    m = int'(sphe_pkg::BOOST_LEVEL);
      9:       m = int'($urandom_range(127));
      default: m = int'($urandom_range(1, 100));
    endcase
    return make_sample(c, t, m, $urandom_range(99) < 65);
  endfunction

  function automatic void count_mismatch(string what, longint unsigned want,
                                         longint unsigned got);
    if (mismatches < MISMATCH_PRINTS)
      $display("mismatch: %s expected %0d got %0d", what, want, got);
    mismatches++;
  endfunction

  function automatic void store_expected(reading_t r);
    expected_fifo[expect_wr % EXPECT_DEPTH] = r;
    expect_wr++;
  endfunction

  function automatic reading_t take_expected();
    reading_t r;
    r = expected_fifo[expect_rd % EXPECT_DEPTH];
    expect_rd++;
    return r;
  endfunction

  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, s.modulation, s.tank, s.collector};
    s_axis_tuser <= s.broadcast;
    do @(posedge clk); while (!s_axis_tready);
    store_expected(estimate_sample(s));
  endtask

  task automatic write_register(logic [sphe_pkg::CFG_IDX_W-1:0] idx,
                                logic [sphe_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sphe_pkg::REG_MIN_MODULATION: min_mod_setting = val[sphe_pkg::MOD_W-1:0];
      sphe_pkg::REG_MAX_FLOW:       max_flow_setting = val[sphe_pkg::FLOW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [sphe_pkg::CFG_DATA_W-1:0] min_mod,
                                logic [sphe_pkg::CFG_DATA_W-1:0] flow);
    write_register(sphe_pkg::REG_MIN_MODULATION, min_mod);
    write_register(sphe_pkg::REG_MAX_FLOW, flow);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expect_wr != expect_rd) @(posedge clk);
  endtask

  // reset settings: zero flow gives zero power, boost masks to zero
  task automatic test_reset_settings();
    send_sample(make_sample(450, 300, 100, 1));
    send_sample(make_sample(450, 300, 100, 1));
    send_sample(make_sample(450, 300, 55, 0));
    drain_results();
  endtask

  task automatic test_boost_masking();
    apply_settings(10'd35, 10'd1000);
    send_sample(make_sample(600, 300, 0, 1));
    send_sample(make_sample(600, 300, 100, 1));
    send_sample(make_sample(600, 300, 100, 1));
    send_sample(make_sample(600, 300, 0, 0));
    send_sample(make_sample(600, 300, 100, 0));
    send_sample(make_sample(650, 320, 64, 1));
    drain_results();
  endtask

  // widest difference both ways, zero difference, registers past their range
  task automatic test_field_extremes();
    apply_settings(10'h3FF, 10'h3FF);
    send_sample(make_sample(32767, -32768, 127, 1));
    send_sample(make_sample(-32768, 32767, 127, 1));
    send_sample(make_sample(500, 500, 50, 1));
    send_sample(make_sample(32767, -32768, 0, 1));
    send_sample(make_sample(32767, -32768, 100, 1));
    send_sample(make_sample(12345, -1, 127, 0));
    drain_results();
  endtask

  task automatic test_spare_registers();
    write_register(REG_SPARE_A, 10'h3FF);
    write_register(REG_SPARE_B, 10'h2AA);
    cfg_valid <= 1'b0;
    send_sample(make_sample(700, 250, 0, 1));
    send_sample(make_sample(700, 250, 100, 1));
    drain_results();
  endtask

  task automatic test_random_traffic(int count, int idle, int stall,
                                     logic [sphe_pkg::CFG_DATA_W-1:0] min_mod,
                                     logic [sphe_pkg::CFG_DATA_W-1:0] flow);
    apply_settings(min_mod, flow);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_sample(random_sample());
    drain_results();
  endtask

  // result side: random stalls and the compare against the oldest expectation
  always @(posedge clk) begin : result_check
    reading_t got;
    reading_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got.modulation = m_axis_tdata[sphe_pkg::MOD_W-1:0];
        got.power = m_axis_tdata[sphe_pkg::MOD_W +: sphe_pkg::POWER_W];
        got.energy = m_axis_tdata[sphe_pkg::MOD_W + sphe_pkg::POWER_W +: sphe_pkg::ENERGY_W];
        if (expect_wr == expect_rd) begin
          count_mismatch("unexpected result, modulation", 0, got.modulation);
        end else begin
          want = take_expected();
          if (got.modulation != want.modulation)
            count_mismatch("modulation_out", want.modulation, got.modulation);
          if (got.power != want.power)
            count_mismatch("solar_power", want.power, got.power);
          if (got.energy != want.energy)
            count_mismatch("energy_last_hour", want.energy, got.energy);
        end
      end
    end
  end

  // ends the run if no transfer happens on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_settings();
    test_boost_masking();
    test_field_extremes();
    test_spare_registers();
    test_random_traffic(250, 0, 0, 10'd0, 10'd1000);
    test_random_traffic(250, 86, 0, 10'd100, 10'd1000);
    test_random_traffic(250, 0, 86, 10'h3FF, 10'h3FF);
    test_random_traffic(250, 21, 21, sphe_pkg::CFG_DATA_W'($urandom_range(1023)),
                        sphe_pkg::CFG_DATA_W'($urandom_range(1023)));
    test_random_traffic(250, 0, 0, 10'd1, 10'd1);
    test_random_traffic(250, 86, 0, sphe_pkg::CFG_DATA_W'($urandom_range(100)),
                        sphe_pkg::CFG_DATA_W'($urandom_range(1000)));
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expect_wr == expect_rd) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+sv
sv/sphe_pkg.sv
sv/sphe_ram.sv
sv/solar_power_hourly_energy.sv
verif/tb_top.sv
